@@ design/typed_value_group_deframer_core_defines.svh @@
// Assertion macros shared by the deframer RTL files.
`ifndef TYPED_VALUE_GROUP_DEFRAMER_CORE_DEFINES_SVH
`define TYPED_VALUE_GROUP_DEFRAMER_CORE_DEFINES_SVH
`ifndef SYNTHESIS
// Check that the antecedent implies the consequent in the same cycle
`define TVGD_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("tvgd: same-cycle check failed");
// Check that the antecedent implies the consequent in the next cycle
`define TVGD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("tvgd: next-cycle check failed");
`else
`define TVGD_ASSERT_SAME(label, ante, cons)
`define TVGD_ASSERT_NEXT(label, ante, cons)
`endif
`endif

@@ design/tvgd_pkg.sv @@
// Package: character codes, parser phases and the result record of the deframer.
package tvgd_pkg;

    localparam logic [7:0] MARK_CHAR  = 8'h25;  // '%'
    localparam logic [7:0] INT_CHAR   = 8'h64;  // 'd'
    localparam logic [7:0] FLOAT_CHAR = 8'h66;  // 'f'

    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 48;
    localparam int OUT_TUSER_W = 2;

    typedef enum logic [4:0] {
        PH_MARK  = 5'b00001,
        PH_HEAD  = 5'b00010,
        PH_TYPE  = 5'b00100,
        PH_WORDS = 5'b01000,
        PH_IDLE  = 5'b10000
    } t_phase;

    typedef struct packed {
        logic [31:0] word_value;
        logic        is_float;
        logic [7:0]  group_count;
        logic [7:0]  word_index;
        logic        last_in_group;
        logic        sequence_done;
    } t_result;

endpackage

@@ design/tvgd_parser.sv @@
// Byte parser: group header decode, word assembly and result generation.
`include "typed_value_group_deframer_core_defines.svh"

module tvgd_parser (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  logic [7:0]            i_data_byte,
    input  logic                  i_first_byte,
    output logic                  o_res_valid,
    output tvgd_pkg::t_result     o_res
);
    import tvgd_pkg::*;

    t_phase      r_phase,  n_phase;
    logic [7:0]  r_decl,   n_decl;
    logic [7:0]  r_seen,   n_seen;
    logic [1:0]  r_pos,    n_pos;
    logic [23:0] r_part,   n_part;
    logic        r_flt,    n_flt;

    logic        restart;
    t_phase      e_phase;
    logic [7:0]  e_decl;
    logic [7:0]  e_seen;
    logic [1:0]  e_pos;
    logic [23:0] e_part;
    logic        e_flt;
    logic        last;

    // Restart the parser on a flagged byte
    assign restart = i_valid && i_first_byte;
    assign e_phase = restart ? PH_MARK : r_phase;
    assign e_decl  = restart ? 8'd0    : r_decl;
    assign e_seen  = restart ? 8'd0    : r_seen;
    assign e_pos   = restart ? 2'd0    : r_pos;
    assign e_part  = restart ? 24'd0   : r_part;
    assign e_flt   = restart ? 1'b0    : r_flt;
    assign last    = ({1'b0, e_seen} + 9'd1) >= {1'b0, e_decl};

    // Advance the phase and build the result for one transfer
    always_comb begin
        n_phase     = r_phase;
        n_decl      = r_decl;
        n_seen      = r_seen;
        n_pos       = r_pos;
        n_part      = r_part;
        n_flt       = r_flt;
        o_res_valid = 1'b0;
        o_res       = '0;
        if (i_valid) begin
            n_phase = e_phase;
            n_decl  = e_decl;
            n_seen  = e_seen;
            n_pos   = e_pos;
            n_part  = e_part;
            n_flt   = e_flt;
            unique case (e_phase)
                PH_MARK: begin
                    if (i_data_byte == MARK_CHAR) begin
                        n_phase = PH_HEAD;
                    end else begin
                        o_res_valid         = 1'b1;
                        o_res.sequence_done = 1'b1;
                        n_phase             = PH_IDLE;
                    end
                end
                PH_HEAD: begin
                    if (i_data_byte == INT_CHAR || i_data_byte == FLOAT_CHAR) begin
                        n_decl  = 8'd1;
                        n_flt   = (i_data_byte != INT_CHAR);
                        n_seen  = 8'd0;
                        n_pos   = 2'd0;
                        n_part  = 24'd0;
                        n_phase = PH_WORDS;
                    end else begin
                        n_decl  = i_data_byte;
                        n_phase = PH_TYPE;
                    end
                end
                PH_TYPE: begin
                    n_flt   = (i_data_byte != INT_CHAR);
                    n_seen  = 8'd0;
                    n_pos   = 2'd0;
                    n_part  = 24'd0;
                    n_phase = (e_decl == 8'd0) ? PH_MARK : PH_WORDS;
                end
                PH_WORDS: begin
                    if (e_pos != 2'd3) begin
                        // Drop the byte into its lane of the partial word
                        unique case (e_pos)
                            2'd0:    n_part = e_part | {16'd0, i_data_byte};
                            2'd1:    n_part = e_part | {8'd0, i_data_byte, 8'd0};
                            default: n_part = e_part | {i_data_byte, 16'd0};
                        endcase
                        n_pos = e_pos + 2'd1;
                    end else begin
                        o_res_valid         = 1'b1;
                        o_res.word_value    = {i_data_byte, e_part};
                        o_res.is_float      = e_flt;
                        o_res.group_count   = e_decl;
                        o_res.word_index    = e_seen;
                        o_res.last_in_group = last;
                        n_seen              = e_seen + 8'd1;
                        n_pos               = 2'd0;
                        n_part              = 24'd0;
                        if (last) begin
                            n_phase = PH_MARK;
                        end
                    end
                end
                PH_IDLE: begin
                    n_phase = PH_IDLE;
                end
                default: begin
                    n_phase = PH_IDLE;
                end
            endcase
        end
    end

    // Hold the parser state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_MARK;
            r_decl  <= 8'd0;
            r_seen  <= 8'd0;
            r_pos   <= 2'd0;
            r_part  <= 24'd0;
            r_flt   <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_decl  <= n_decl;
            r_seen  <= n_seen;
            r_pos   <= n_pos;
            r_part  <= n_part;
            r_flt   <= n_flt;
        end
    end

    `TVGD_ASSERT_SAME(a_words_nonempty, r_phase == PH_WORDS, r_decl != 8'd0)
    `TVGD_ASSERT_SAME(a_seen_below_decl, r_phase == PH_WORDS, r_seen < r_decl)
    `TVGD_ASSERT_SAME(a_pos_only_in_words, r_phase != PH_WORDS, r_pos == 2'd0)

endmodule

@@ design/typed_value_group_deframer_core.sv @@
// Top level of the typed value group deframer: parser plus two-entry output stage.
//
//  channel | direction | tdata                                    | tuser              | tlast
//  s       | in        | [7:0] data_byte                          | [0] first_byte     | -
//  m       | out       | [31:0] word_value, [39:32] group_count,  | [0] is_float,      | last_in_group
//          |           | [47:40] word_index                       | [1] sequence_done  |
//
// One byte is taken per cycle while o_s_tready is high. The result that a byte
// completes is registered in the output stage. The parser state update is the only
// logic on the input path. A skid register behind the output register keeps
// o_s_tready a registered signal: it falls only when both output entries are full.
// Reset is synchronous on i_rst_n and returns the parser to waiting for a '%'.
`include "typed_value_group_deframer_core_defines.svh"

module typed_value_group_deframer_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    input  logic [tvgd_pkg::IN_TDATA_W-1:0]   i_s_tdata,  // [7:0] data_byte
    input  logic                              i_s_tuser,  // [0] first_byte
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    output logic [tvgd_pkg::OUT_TDATA_W-1:0]  o_m_tdata,  // word_value, group_count, word_index
    output logic [tvgd_pkg::OUT_TUSER_W-1:0]  o_m_tuser,  // is_float, sequence_done
    output logic                              o_m_tlast
);
    import tvgd_pkg::*;

    logic    s_accept;
    logic    res_valid;
    t_result res;
    logic    push;
    logic    pop;

    logic    r_out_valid;
    t_result r_out;
    logic    r_skid_valid;
    t_result r_skid;

    assign o_s_tready = !r_skid_valid;
    assign s_accept   = i_s_tvalid && o_s_tready;

    tvgd_parser u_parser (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (s_accept),
        .i_data_byte  (i_s_tdata),
        .i_first_byte (i_s_tuser),
        .o_res_valid  (res_valid),
        .o_res        (res)
    );

    assign push = res_valid;
    assign pop  = r_out_valid && i_m_tready;

    // Advance the output register and the skid entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (pop) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end
        end else if (push) begin
            if (!r_out_valid || pop) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (pop) begin
            r_out_valid <= 1'b0;
        end
    end

    // Move result payloads; no reset needed
    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (pop) begin
                r_out <= r_skid;
            end
        end else if (push) begin
            if (!r_out_valid || pop) begin
                r_out <= res;
            end else begin
                r_skid <= res;
            end
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {r_out.word_index, r_out.group_count, r_out.word_value};
    assign o_m_tuser  = {r_out.sequence_done, r_out.is_float};
    assign o_m_tlast  = r_out.last_in_group;

    `TVGD_ASSERT_SAME(a_skid_behind_out, r_skid_valid, r_out_valid)
    `TVGD_ASSERT_NEXT(a_stall_fills_skid, r_out_valid && !i_m_tready && !r_skid_valid && push, r_skid_valid)
    `TVGD_ASSERT_NEXT(a_drain_empties, pop && !r_skid_valid && !push, !r_out_valid)

endmodule

@@ verif/tb_typed_value_group_deframer_core.sv @@
// Self-checking testbench for the typed value group deframer: byte stream in, typed words out.
module tb_typed_value_group_deframer_core;
    import tvgd_pkg::*;

    typedef struct packed {
        logic [7:0] data;
        logic       first;
    } t_stream_byte;

    logic                    i_clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    s_valid = 1'b0;
    logic [IN_TDATA_W-1:0]   s_data = '0;
    logic                    s_first = 1'b0;
    logic                    m_ready = 1'b0;
    logic                    s_ready;
    logic                    m_valid;
    logic [OUT_TDATA_W-1:0]  m_data;
    logic [OUT_TUSER_W-1:0]  m_user;
    logic                    m_last;

    // bytes still to be offered, and words the parser is known to owe
    t_stream_byte byte_q[$];
    t_result      word_q[$];
    int           errors = 0;

    // predicted parser state
    t_phase       p_phase = PH_MARK;
    logic [7:0]   p_declared = '0;
    logic [7:0]   p_seen_cnt = '0;
    logic [1:0]   p_bpos = '0;
    logic [23:0]  p_partial = '0;
    logic         p_float = 1'b0;

    // idling state of both sides
    int           tx_gap = 0;
    int           n_tx = 0;
    bit           tx_burst = 1'b0;
    int           rx_stall = 0;
    int           n_rx = 0;
    bit           rx_burst = 1'b0;
    int           cyc = 0;
    logic         rx_hold = 1'b0;

    typed_value_group_deframer_core DUT (
        .i_clk      (i_clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_valid),
        .o_s_tready (s_ready),
        .i_s_tdata  (s_data),   // [7:0] data_byte
        .i_s_tuser  (s_first),  // [0] first_byte
        .o_m_tvalid (m_valid),
        .i_m_tready (m_ready),
        .o_m_tdata  (m_data),   // [31:0] word_value, [39:32] group_count, [47:40] word_index
        .o_m_tuser  (m_user),   // [0] is_float, [1] sequence_done
        .o_m_tlast  (m_last)    // last_in_group
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Clear the word counters and choose between word collection and the next marker
    task automatic open_words();
        p_seen_cnt = '0;
        p_bpos     = '0;
        p_partial  = '0;
        p_phase    = (p_declared == 8'd0) ? PH_MARK : PH_WORDS;
    endtask

    // Advance the predicted parser by one byte and queue any word it yields
    task automatic parse_byte(input logic [7:0] b, input logic first);
        t_result r;
        logic    last;
        r = '0;
        if (first) begin
            p_phase    = PH_MARK;
            p_declared = '0;
            p_seen_cnt = '0;
            p_bpos     = '0;
            p_partial  = '0;
            p_float    = 1'b0;
        end
        case (p_phase)
            PH_MARK: begin
                if (b == MARK_CHAR) begin
                    p_phase = PH_HEAD;
                end else begin
                    r.sequence_done = 1'b1;
                    word_q.push_back(r);
                    p_phase = PH_IDLE;
                end
            end
            PH_HEAD: begin
                if (b == INT_CHAR || b == FLOAT_CHAR) begin
                    p_declared = 8'd1;
                    p_float    = (b != INT_CHAR);
                    open_words();
                end else begin
                    p_declared = b;
                    p_phase    = PH_TYPE;
                end
            end
            PH_TYPE: begin
                p_float = (b != INT_CHAR);
                open_words();
            end
            PH_WORDS: begin
                if (p_bpos != 2'd3) begin
                    p_partial[p_bpos*8 +: 8] = b;
                    p_bpos = p_bpos + 2'd1;
                end else begin
                    last = ({1'b0, p_seen_cnt} + 9'd1) >= {1'b0, p_declared};
                    r.word_value    = {b, p_partial};
                    r.is_float      = p_float;
                    r.group_count   = p_declared;
                    r.word_index    = p_seen_cnt;
                    r.last_in_group = last;
                    word_q.push_back(r);
                    p_seen_cnt = p_seen_cnt + 8'd1;
                    p_bpos     = '0;
                    p_partial  = '0;
                    if (last) p_phase = PH_MARK;
                end
            end
            default: p_phase = PH_IDLE;
        endcase
    endtask

    // Drive the byte stream: one transfer per item, random gaps between items
    always @(posedge i_clk) begin : byte_driver
        logic nxt_valid;
        if (!rst_n) begin
            s_valid <= 1'b0;
            tx_gap = $urandom_range(0, 15);
        end else begin
            nxt_valid = s_valid;
            if (s_valid && s_ready) begin
                parse_byte(s_data, s_first);
                byte_q.delete(0);
                nxt_valid = 1'b0;
                n_tx++;
                if (n_tx % 50 == 0) tx_burst = ($urandom_range(0, 2) == 0);
                tx_gap = tx_burst ? 0 : $urandom_range(0, 15);
            end
            if (!nxt_valid) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                end else if (byte_q.size() != 0) begin
                    nxt_valid = 1'b1;
                    s_data  <= byte_q[0].data;
                    s_first <= byte_q[0].first;
                end
            end
            s_valid <= nxt_valid;
        end
    end

    // Hold the receiver off for two long stretches so the output stage fills up
    always @(posedge i_clk) begin
        if (!rst_n) begin
            cyc     <= 0;
            rx_hold <= 1'b0;
        end else begin
            cyc     <= cyc + 1;
            rx_hold <= (cyc >= 1500 && cyc < 1800) || (cyc >= 6000 && cyc < 6300);
        end
    end

    // Check each result transfer against the oldest predicted word
    always @(posedge i_clk) begin : result_monitor
        t_result got_r;
        t_result want_r;
        if (!rst_n) begin
            m_ready <= 1'b0;
            rx_stall = 0;
        end else begin
            if (m_valid && m_ready) begin
                got_r.word_value    = m_data[31:0];
                got_r.is_float      = m_user[0];
                got_r.group_count   = m_data[39:32];
                got_r.word_index    = m_data[47:40];
                got_r.last_in_group = m_last;
                got_r.sequence_done = m_user[1];
                if (word_q.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result, actual word=%h flt=%b cnt=%0d idx=%0d last=%b done=%b",
                             $time, got_r.word_value, got_r.is_float, got_r.group_count,
                             got_r.word_index, got_r.last_in_group, got_r.sequence_done);
                end else begin
                    want_r = word_q.pop_front();
                    if (got_r !== want_r) begin
                        errors++;
                        $display("%0t: mismatch, expected word=%h flt=%b cnt=%0d idx=%0d last=%b done=%b",
                                 $time, want_r.word_value, want_r.is_float, want_r.group_count,
                                 want_r.word_index, want_r.last_in_group, want_r.sequence_done);
                        $display("%0t:           actual   word=%h flt=%b cnt=%0d idx=%0d last=%b done=%b",
                                 $time, got_r.word_value, got_r.is_float, got_r.group_count,
                                 got_r.word_index, got_r.last_in_group, got_r.sequence_done);
                    end
                end
                n_rx++;
                if (n_rx % 40 == 0) rx_burst = ($urandom_range(0, 2) == 0);
                rx_stall = rx_burst ? 0 : $urandom_range(0, 15);
            end else if (rx_stall > 0) begin
                rx_stall--;
            end
            m_ready <= (rx_stall == 0) && !rx_hold;
        end
    end

    int n_gen = 0;

    task automatic push_byte(input logic [7:0] b, input logic f);
        byte_q.push_back('{data: b, first: f});
        n_gen++;
    endtask

    // Build the stimulus, release reset and wait for the stream to drain
    initial begin
        int n_grp;
        int cnt;
        bit broken;
        logic [7:0] tb;
        t_stream_byte ign;

        // single-word float group of zeros, short form
        push_byte(MARK_CHAR, 1'b1);
        push_byte(FLOAT_CHAR, 1'b0);
        repeat (4) push_byte(8'h00, 1'b0);
        // two-word integer group, counted form, all-ones then sign bit set
        push_byte(MARK_CHAR, 1'b0);
        push_byte(8'd2, 1'b0);
        push_byte(INT_CHAR, 1'b0);
        repeat (4) push_byte(8'hFF, 1'b0);
        push_byte(8'h01, 1'b0);
        push_byte(8'h02, 1'b0);
        push_byte(8'h03, 1'b0);
        push_byte(8'h80, 1'b0);
        // empty group with an unusual type byte
        push_byte(MARK_CHAR, 1'b0);
        push_byte(8'd0, 1'b0);
        push_byte(8'h71, 1'b0);
        // a non-marker ends the sequence, then a marker is ignored
        push_byte(INT_CHAR, 1'b0);
        push_byte(MARK_CHAR, 1'b0);
        // restart in the middle of a word
        push_byte(MARK_CHAR, 1'b1);
        push_byte(INT_CHAR, 1'b0);
        push_byte(8'hAA, 1'b0);
        push_byte(8'hBB, 1'b0);
        // restart straight into a done result
        push_byte(8'h00, 1'b1);

        // one group of the largest count
        push_byte(MARK_CHAR, 1'b1);
        push_byte(8'd255, 1'b0);
        push_byte(8'h80, 1'b0);
        repeat (1020) push_byte(8'($urandom_range(0, 255)), 1'b0);
        push_byte(8'h58, 1'b0);

        // random sequences, mostly well formed, up to the item budget
        while (n_gen < 1100) begin
            if ($urandom_range(0, 9) == 0) begin
                repeat ($urandom_range(1, 6))
                    push_byte(8'($urandom_range(0, 255)), ($urandom_range(0, 3) == 0));
            end else begin
                n_grp  = $urandom_range(0, 4);
                broken = 1'b0;
                for (int g = 0; g < n_grp && !broken; g++) begin
                    push_byte(MARK_CHAR, g == 0);
                    if ($urandom_range(0, 3) == 0) begin
                        push_byte($urandom_range(0, 1) ? FLOAT_CHAR : INT_CHAR, 1'b0);
                        cnt = 1;
                    end else begin
                        cnt = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 12)
                                                         : $urandom_range(0, 4);
                        push_byte(cnt[7:0], 1'b0);
                        push_byte($urandom_range(0, 1) ? INT_CHAR : 8'($urandom_range(0, 255)),
                                  1'b0);
                    end
                    for (int w = 0; w < cnt * 4; w++) begin
                        // drop out mid-group now and then; a later flagged first byte restarts the parser
                        if ($urandom_range(0, 199) == 0) begin
                            broken = 1'b1;
                            break;
                        end
                        push_byte(8'($urandom_range(0, 255)), 1'b0);
                    end
                end
                if (!broken && $urandom_range(0, 3) != 0) begin
                    do tb = 8'($urandom_range(0, 255)); while (tb == MARK_CHAR);
                    push_byte(tb, n_grp == 0);
                    // trailing bytes after done are ignored by the parser
                    repeat ($urandom_range(0, 3)) begin
                        ign.data  = 8'($urandom_range(0, 255));
                        ign.first = 1'b0;
                        byte_q.push_back(ign);
                    end
                end
            end
        end

        repeat (2) @(posedge i_clk);
        rst_n <= 1'b1;

        while (byte_q.size() != 0 || word_q.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        if (errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    // Guard against a hung handshake
    initial begin
        #3000000;
        $display("status: fail");
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+design
design/tvgd_pkg.sv
design/tvgd_parser.sv
design/typed_value_group_deframer_core.sv
verif/tb_typed_value_group_deframer_core.sv
